/* sv/nsf_pkg.sv */
// nsf_pkg: shared types and constants of the NMEA sentence framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package nsf_pkg;

  localparam int unsigned MAX_BODY_DEF = 256;

  localparam logic [7:0]  CH_START  = 8'h24;
  localparam logic [7:0]  CH_COMMA  = 8'h2c;
  localparam logic [7:0]  CH_STAR   = 8'h2a;
  localparam logic [39:0] HDR_RESET = 40'h4750524D43;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_HEX  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [8:0]  sentence_len;
    logic [7:0]  computed_sum;
    logic [7:0]  given_sum;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t item;
  } push_t;

endpackage

/* sv/nsf_in_if.sv */
// nsf_in_if: byte channel into the framer (valid, ready, rx_byte).
// No dependencies.
`timescale 1ns / 1ps
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/nsf_out_if.sv */
// nsf_out_if: result channel out of the framer.
// Uses nsf_pkg for the status and kind types.
`timescale 1ns / 1ps
interface nsf_out_if;
  import nsf_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      item_kind;
  logic [7:0] data_byte;
  status_t    status;
  logic [8:0] sentence_len;
  logic [7:0] computed_sum;
  logic [7:0] given_sum;
  logic       last;

  modport source (output valid, output item_kind, output data_byte, output status,
                  output sentence_len, output computed_sum, output given_sum,
                  output last, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input status,
                  input sentence_len, input computed_sum, input given_sum,
                  input last, output ready);
endinterface

/* sv/nmea_sentence_framer.sv */
// nmea_sentence_framer: NMEA 0183 sentence framer with XOR checksum check.
// Throughput: one byte beat per cycle while the result queue has room; a matched header
//   stalls input while the header and comma replay from the parser into the result queue.
// Timing: a body or status beat is pushed into the result queue in the same cycle as
//   its byte is taken; the header and comma beats follow the accepted comma byte.
// Reset: synchronous active-low rst_n; parser hunts for '$', queue is empty,
//   header register returns to GPRMC. Depends on nsf_pkg, nsf_parser, nsf_out_fifo.
`timescale 1ns / 1ps
module nmea_sentence_framer
  import nsf_pkg::*;
#(
  parameter int unsigned MAX_BODY = MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nsf_in_if.sink      in_ch,
  nsf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata
);

  logic [39:0] header_word_r;
  logic [1:0]  free;
  push_t       wr;
  result_t     head;
  logic        head_valid;
  logic        in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_word_r <= HDR_RESET;
    end else if (cfg_we) begin
      header_word_r <= cfg_wdata;
    end
  end

  nsf_parser #(.MAX_BODY(MAX_BODY)) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_byte     (in_ch.rx_byte),
    .in_ready    (in_ready),
    .header_word (header_word_r),
    .free        (free),
    .wr          (wr)
  );

  nsf_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .pop        (out_ch.ready),
    .head_valid (head_valid),
    .head       (head),
    .free       (free)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = head_valid;
  assign out_ch.item_kind    = head.item_kind;
  assign out_ch.data_byte    = head.data_byte;
  assign out_ch.status       = head.status;
  assign out_ch.sentence_len = head.sentence_len;
  assign out_ch.computed_sum = head.computed_sum;
  assign out_ch.given_sum    = head.given_sum;
  assign out_ch.last         = head.last;

endmodule

/* sv/nsf_out_fifo.sv */
// nsf_out_fifo: two-entry result queue that decouples parser and sink.
// Uses nsf_pkg for result_t and push_t.
`timescale 1ns / 1ps
module nsf_out_fifo
  import nsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      wr,
  input  logic       pop,
  output logic       head_valid,
  output result_t    head,
  output logic [1:0] free
);

  result_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign free       = 2'd2 - count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r + {1'b0, wr.push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr.push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) mem_r[wr_ptr_r] <= wr.item;
  end

endmodule

/* sv/nsf_parser.sv */
// nsf_parser: sentence state machine, running XOR and header replay.
// Uses nsf_pkg; pushes result beats into nsf_out_fifo.
`timescale 1ns / 1ps
module nsf_parser
  import nsf_pkg::*;
#(
  parameter int unsigned MAX_BODY = MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_ready,
  input  logic [39:0] header_word,
  input  logic [1:0]  free,
  output push_t       wr
);

  localparam int unsigned BW = $clog2(MAX_BODY + 1);

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_COMMA  = 6'b000100,
    PH_BODY   = 6'b001000,
    PH_HEX1   = 6'b010000,
    PH_HEX2   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [39:0] hdr_r, hdr_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [BW-1:0] body_cnt_r, body_cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        hi_bad_r, hi_bad_nxt;
  logic [47:0] emit_r, emit_nxt;
  logic [2:0]  emit_cnt_r, emit_cnt_nxt;
  logic        accept;
  logic [3:0]  dig;
  logic        dig_ok;
  logic [7:0]  given;
  logic [9:0]  len_wide;
  logic [8:0]  len;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  assign in_ready = (emit_cnt_r == 3'd0) && (free != 2'd0);
  assign accept   = in_valid && in_ready;
  assign {dig_ok, dig} = hex_dec(in_byte);
  assign given    = {hi_r, dig};
  assign len_wide = 10'd6 + 10'(body_cnt_r);
  assign len      = (len_wide > 10'd511) ? 9'h1FF : len_wide[8:0];

  always_comb begin
    phase_nxt    = phase_r;
    hdr_nxt      = hdr_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    body_cnt_nxt = body_cnt_r;
    xor_nxt      = xor_r;
    hi_nxt       = hi_r;
    hi_bad_nxt   = hi_bad_r;
    emit_nxt     = emit_r;
    emit_cnt_nxt = emit_cnt_r;
    wr           = '0;
    wr.item.item_kind    = KIND_DATA;
    wr.item.status       = ST_OK;

    if (emit_cnt_r != 3'd0) begin
      if (free != 2'd0) begin
        wr.push           = 1'b1;
        wr.item.data_byte = emit_r[47:40];
        emit_nxt          = {emit_r[39:0], 8'h00};
        emit_cnt_nxt      = emit_cnt_r - 3'd1;
      end
    end else if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt     = {hdr_r[31:0], in_byte};
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_cnt_nxt >= 3'd5) phase_nxt = PH_COMMA;
        end
        PH_COMMA: begin
          if (hdr_r == header_word) begin
            xor_nxt      = hdr_r[39:32] ^ hdr_r[31:24] ^ hdr_r[23:16] ^
                           hdr_r[15:8] ^ hdr_r[7:0] ^ CH_COMMA;
            emit_nxt     = {hdr_r, CH_COMMA};
            emit_cnt_nxt = 3'd6;
            body_cnt_nxt = '0;
            phase_nxt    = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (in_byte == CH_STAR) begin
            phase_nxt = PH_HEX1;
          end else if (body_cnt_r < BW'(MAX_BODY)) begin
            xor_nxt           = xor_r ^ in_byte;
            body_cnt_nxt      = body_cnt_r + BW'(1);
            wr.push           = 1'b1;
            wr.item.data_byte = in_byte;
          end else begin
            wr.push              = 1'b1;
            wr.item.item_kind    = KIND_STATUS;
            wr.item.status       = ST_OVERFLOW;
            wr.item.sentence_len = len;
            wr.item.computed_sum = xor_r;
            wr.item.last         = 1'b1;
            phase_nxt            = PH_HUNT;
          end
        end
        PH_HEX1: begin
          hi_bad_nxt = !dig_ok;
          hi_nxt     = dig;
          phase_nxt  = PH_HEX2;
        end
        PH_HEX2: begin
          wr.push              = 1'b1;
          wr.item.item_kind    = KIND_STATUS;
          wr.item.sentence_len = len;
          wr.item.computed_sum = xor_r;
          wr.item.last         = 1'b1;
          if (!dig_ok || hi_bad_r) begin
            wr.item.status = ST_BAD_HEX;
          end else begin
            wr.item.given_sum = given;
            wr.item.status    = (given == xor_r) ? ST_OK : ST_MISMATCH;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          if (in_byte == CH_START) begin
            hdr_nxt      = '0;
            hdr_cnt_nxt  = '0;
            body_cnt_nxt = '0;
            xor_nxt      = '0;
            phase_nxt    = PH_HEADER;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_r      <= '0;
      hdr_cnt_r  <= '0;
      body_cnt_r <= '0;
      xor_r      <= '0;
      hi_r       <= '0;
      hi_bad_r   <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_r      <= hdr_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      body_cnt_r <= body_cnt_nxt;
      xor_r      <= xor_nxt;
      hi_r       <= hi_nxt;
      hi_bad_r   <= hi_bad_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_r <= emit_nxt;
  end

endmodule

/* sv/nsf_checker.sv */
// nsf_checker: port-level assertions on the framer's result channel.
// Uses nsf_pkg; bound to nmea_sentence_framer below.
`timescale 1ns / 1ps
module nsf_checker
  import nsf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input kind_t      item_kind,
  input status_t    status,
  input logic [8:0] sentence_len,
  input logic [7:0] given_sum,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_DATA |-> !last && sentence_len == 9'd0)
    else $error("data beat carries status fields");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_STATUS |-> last && sentence_len >= 9'd6)
    else $error("status beat without last or short length");

  a_given_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_BAD_HEX || status == ST_OVERFLOW) |-> given_sum == 8'd0)
    else $error("given sum set on failed sentence");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .item_kind    (out_ch.item_kind),
  .status       (out_ch.status),
  .sentence_len (out_ch.sentence_len),
  .given_sum    (out_ch.given_sum),
  .last         (out_ch.last)
);

/* test/nmea_sentence_framer_test.sv */
// nmea_sentence_framer_test: self-checking bench for the NMEA sentence framer.
// Queues sentences (good, bad sum, bad hex, header miss, no comma, truncated, overflow, noise),
// predicts each result beat in-bench, and checks it. Needs nsf_pkg, nsf_in_if, nsf_out_if.
`timescale 1ns / 1ps
module nmea_sentence_framer_test;
  import nsf_pkg::*;

  localparam int unsigned BODY_LIMIT    = MAX_BODY_DEF;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned STALL_LEN     = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES  = 100;

  typedef enum logic [2:0] {
    P_HUNT, P_HEADER, P_COMMA, P_BODY, P_HEX1, P_HEX2
  } parse_phase_t;

  typedef enum int {
    SK_GOOD, SK_BADSUM, SK_BADHEX_HI, SK_BADHEX_LO, SK_HDR_MISS,
    SK_NOCOMMA, SK_TRUNC, SK_OVERFLOW, SK_NOISE
  } sentence_kind_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [39:0] cfg_wdata;

  nsf_in_if  in_ch ();
  nsf_out_if out_ch ();

  nmea_sentence_framer #(.MAX_BODY(BODY_LIMIT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // framer state mirrored in the bench
  parse_phase_t ph;
  logic [39:0]  hdr_word;
  logic [39:0]  hdr_shift;
  logic [2:0]   hdr_cnt;
  logic [8:0]   body_cnt;
  logic [7:0]   run_xor;
  logic [3:0]   hi_nib;
  logic         hi_bad;

  logic [7:0]  rx_backlog[$];
  logic [7:0]  directed_body[$];
  result_t     pending_results[$];

  int unsigned queued_bytes;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned stall_cycles;
  logic        stall_armed;
  logic        src_calm;
  logic        sink_calm;
  logic        sink_held;
  result_t     got_beat;
  result_t     want_beat;

  assign sink_held = stall_armed && (stall_cycles < STALL_LEN);

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_data(input logic [7:0] b);
    result_t r;
    r = '0;
    r.item_kind = KIND_DATA;
    r.status    = ST_OK;
    r.data_byte = b;
    pending_results.push_back(r);
  endfunction

  function automatic void push_status(input status_t st, input logic [7:0] given);
    result_t r;
    logic [9:0] len;
    len = 10'd6 + body_cnt;
    r = '0;
    r.item_kind    = KIND_STATUS;
    r.status       = st;
    r.sentence_len = (len > 10'd511) ? 9'd511 : len[8:0];
    r.computed_sum = run_xor;
    r.given_sum    = given;
    r.last         = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [3:0] nib;
    logic [7:0] c;
    logic [7:0] given;
    logic       ok;
    case (ph)
      P_HEADER: begin
        hdr_shift = {hdr_shift[31:0], b};
        hdr_cnt   = hdr_cnt + 3'd1;
        if (hdr_cnt >= 3'd5) ph = P_COMMA;
      end
      P_COMMA: begin
        if (hdr_shift == hdr_word) begin
          run_xor = 8'd0;
          for (int i = 0; i < 5; i++) begin
            c = hdr_shift[39 - 8 * i -: 8];
            run_xor ^= c;
            push_data(c);
          end
          run_xor ^= CH_COMMA;
          push_data(CH_COMMA);
          body_cnt = 9'd0;
          ph = P_BODY;
        end else begin
          ph = P_HUNT;
        end
      end
      P_BODY: begin
        if (b == CH_STAR) begin
          ph = P_HEX1;
        end else if (body_cnt < BODY_LIMIT) begin
          run_xor ^= b;
          body_cnt = body_cnt + 9'd1;
          push_data(b);
        end else begin
          push_status(ST_OVERFLOW, 8'd0);
          ph = P_HUNT;
        end
      end
      P_HEX1: begin
        hi_bad = !hex_digit(b, nib);
        hi_nib = nib;
        ph = P_HEX2;
      end
      P_HEX2: begin
        ok = hex_digit(b, nib) && !hi_bad;
        if (!ok) begin
          push_status(ST_BAD_HEX, 8'd0);
        end else begin
          given = {hi_nib, nib};
          push_status((given == run_xor) ? ST_OK : ST_MISMATCH, given);
        end
        ph = P_HUNT;
      end
      default: begin
        if (b == CH_START) begin
          hdr_shift = '0;
          hdr_cnt   = '0;
          body_cnt  = '0;
          run_xor   = '0;
          ph = P_HEADER;
        end else begin
          ph = P_HUNT;
        end
      end
    endcase
  endfunction

  function automatic void queue_rx(input logic [7:0] b);
    rx_backlog.push_back(b);
    queued_bytes++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return ($urandom_range(0, 1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [3:0] v;
    do b = 8'($urandom_range(0, 255)); while (hex_digit(b, v));
    return b;
  endfunction

  function automatic void queue_sentence(input sentence_kind_t kind, input int body_len);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    int         miss_pos;
    miss_pos = $urandom_range(0, 4);
    if (kind == SK_NOISE) begin
      repeat ($urandom_range(1, 6)) queue_rx(8'($urandom_range(0, 255)));
      return;
    end
    sum = CH_COMMA;
    queue_rx(CH_START);
    for (int i = 0; i < 5; i++) begin
      b = hdr_word[39 - 8 * i -: 8];
      if (kind == SK_HDR_MISS && i == miss_pos) b ^= 8'(1 << $urandom_range(0, 7));
      sum ^= b;
      queue_rx(b);
    end
    if (kind == SK_NOCOMMA) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
      queue_rx(b);
    end else begin
      queue_rx(CH_COMMA);
    end
    for (int i = 0; i < body_len; i++) begin
      if (directed_body.size() != 0) begin
        b = directed_body.pop_front();
      end else if ($urandom_range(0, 9) == 0) begin
        b = CH_START;
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
      end
      sum ^= b;
      queue_rx(b);
    end
    if (kind == SK_TRUNC) return;
    queue_rx(CH_STAR);
    if (kind == SK_BADSUM) sum ^= 8'(1 << $urandom_range(0, 7));
    hi_c = hex_char(sum[7:4]);
    lo_c = hex_char(sum[3:0]);
    if (kind == SK_BADHEX_HI) hi_c = non_hex_byte();
    if (kind == SK_BADHEX_LO) lo_c = non_hex_byte();
    queue_rx(hi_c);
    queue_rx(lo_c);
  endfunction

  function automatic void queue_random_sentence();
    int unsigned pick;
    sentence_kind_t kind;
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = SK_GOOD;
    else if (pick < 55) kind = SK_BADSUM;
    else if (pick < 62) kind = SK_BADHEX_HI;
    else if (pick < 69) kind = SK_BADHEX_LO;
    else if (pick < 76) kind = SK_HDR_MISS;
    else if (pick < 83) kind = SK_NOCOMMA;
    else if (pick < 90) kind = SK_TRUNC;
    else                kind = SK_NOISE;
    queue_sentence(kind, $urandom_range(0, 16));
  endfunction

  function automatic void report_beat(input string what, input result_t want,
                                      input result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp kind=%0d byte=%02h st=%0d len=%0d sum=%02h given=%02h last=%0d",
               $realtime, what, want.item_kind, want.data_byte, want.status,
               want.sentence_len, want.computed_sum, want.given_sum, want.last);
      $display("%0t %s: got kind=%0d byte=%02h st=%0d len=%0d sum=%02h given=%02h last=%0d",
               $realtime, what, got.item_kind, got.data_byte, got.status,
               got.sentence_len, got.computed_sum, got.given_sum, got.last);
    end
  endfunction

  // wait until every queued byte is taken and every predicted beat has come back
  task automatic settle();
    do @(posedge clk);
    while (rx_backlog.size() != 0 || in_ch.valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input logic [39:0] w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hdr_word = w;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_rx_byte(in_ch.rx_byte);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_backlog.size() != 0 && (src_calm || $urandom_range(0, 99) >= 17)) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= rx_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (sink_held) stall_cycles <= stall_cycles + 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_beat.item_kind    = out_ch.item_kind;
        got_beat.data_byte    = out_ch.data_byte;
        got_beat.status       = out_ch.status;
        got_beat.sentence_len = out_ch.sentence_len;
        got_beat.computed_sum = out_ch.computed_sum;
        got_beat.given_sum    = out_ch.given_sum;
        got_beat.last         = out_ch.last;
        if (pending_results.size() == 0) begin
          report_beat("unexpected beat", '0, got_beat);
        end else begin
          want_beat = pending_results.pop_front();
          if (got_beat !== want_beat) report_beat("mismatch", want_beat, got_beat);
        end
      end
      out_ch.ready <= !sink_held && (sink_calm || $urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    int unsigned rand_start;
    int unsigned round;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    stall_armed   = 1'b0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    stall_cycles  = 0;
    cycle_count   = 0;
    queued_bytes  = 0;
    fail_count    = 0;
    hdr_word      = HDR_RESET;
    ph            = P_HUNT;
    hdr_shift     = '0;
    hdr_cnt       = '0;
    body_cnt      = '0;
    run_xor       = '0;
    hi_nib        = '0;
    hi_bad        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset header, byte extremes, '$' in body, header miss, bad hex
    queue_rx(8'h00);
    queue_rx(8'hFF);
    directed_body = '{8'h00, 8'hFF, CH_START};
    queue_sentence(SK_GOOD, 3);
    queue_sentence(SK_HDR_MISS, 0);
    queue_sentence(SK_BADHEX_LO, 1);
    settle();

    // pressure: receiver holds off while a long sentence backs up the block,
    // then both sides run without idling
    write_header("GPGGA");
    stall_armed <= 1'b1;
    src_calm    <= 1'b1;
    sink_calm   <= 1'b1;
    queue_sentence(SK_OVERFLOW, BODY_LIMIT + 2);
    queue_sentence(SK_GOOD, 10);
    settle();
    src_calm  <= 1'b0;
    sink_calm <= 1'b0;

    rand_start = queued_bytes;
    round = 0;
    while (queued_bytes - rand_start < RANDOM_BYTES) begin
      settle();
      case (round)
        0:       write_header(40'h00_0000_0000);
        1:       write_header(40'hFF_FFFF_FFFF);
        2:       write_header(HDR_RESET);
        default: write_header({8'($urandom_range(0, 255)), 32'($urandom)});
      endcase
      src_calm  <= (round == 1);
      sink_calm <= (round == 1);
      repeat (2) queue_random_sentence();
      round++;
    end
    settle();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
